@@ hw/rtl/vtp_pkg.sv @@
// Package for the VT escape sequence parser: parser states, actions, constants.
// No dependencies.
package vtp_pkg;

  localparam int unsigned MaxParamsDef   = 16;
  localparam int unsigned OscBufBytesDef = 256;
  localparam int unsigned CodeW          = 21;
  localparam int unsigned ValW           = 17;
  localparam logic [ValW-1:0] ParamCap   = 17'd9999;

  typedef enum logic [3:0] {
    StGround   = 4'd0,
    StEsc      = 4'd1,
    StEscInt   = 4'd2,
    StCsiEntry = 4'd3,
    StCsiParam = 4'd4,
    StCsiInt   = 4'd5,
    StCsiIgn   = 4'd6,
    StOscParam = 4'd7,
    StOscStr   = 4'd8
  } pstate_e;

  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActSend    = 3'd1,
    ActCollect = 3'd2,
    ActParam   = 3'd3,
    ActOsc     = 3'd4,
    ActOscEnd  = 3'd5
  } act_e;

  localparam logic [1:0] KindDispatch = 2'd0;
  localparam logic [1:0] KindPrint    = 2'd1;
  localparam logic [1:0] KindOscByte  = 2'd2;
  localparam logic [1:0] KindOscEnd   = 2'd3;

  localparam logic [1:0] ClsGround = 2'd0;
  localparam logic [1:0] ClsEsc    = 2'd1;
  localparam logic [1:0] ClsCsi    = 2'd2;
  localparam logic [1:0] ClsOsc    = 2'd3;

  typedef struct packed {
    act_e    act;
    logic    chg;
    pstate_e nxt;
  } decode_t;

  function automatic logic [1:0] class_of(pstate_e st);
    case (st)
      StGround:             class_of = ClsGround;
      StEsc, StEscInt:      class_of = ClsEsc;
      StOscParam, StOscStr: class_of = ClsOsc;
      default:              class_of = ClsCsi;
    endcase
  endfunction

endpackage

@@ hw/rtl/vtp_decode.sv @@
// Transition table of the escape parser: action and next state per character.
// Depends on vtp_pkg.
module vtp_decode import vtp_pkg::*; (
  input  pstate_e    st_i,
  input  logic [6:0] c_i,
  output decode_t    dec_o
);

  always_comb begin
    dec_o = '{act: ActNone, chg: 1'b0, nxt: StGround};
    if (c_i < 7'h20) begin
      if ((st_i == StOscParam || st_i == StOscStr) && c_i == 7'h07) begin
        dec_o = '{act: ActOscEnd, chg: 1'b1, nxt: StGround};
      end else if (st_i == StOscStr && (c_i == 7'h0a || c_i == 7'h0d)) begin
        dec_o = '{act: ActOscEnd, chg: 1'b1, nxt: StGround};
      end else if (c_i == 7'h00) begin
        dec_o.act = ActNone;
      end else if (c_i == 7'h1b) begin
        dec_o = '{act: ActNone, chg: 1'b1, nxt: StEsc};
      end else begin
        dec_o.act = ActSend;
        dec_o.chg = (c_i == 7'h18 || c_i == 7'h1a);
      end
    end else begin
      case (st_i)
        StGround: dec_o.act = ActSend;
        StEsc: begin
          if (c_i == 7'h21 || c_i == 7'h50 || c_i == 7'h5e || c_i == 7'h5f || c_i == 7'h6b)
            dec_o = '{act: ActNone, chg: 1'b1, nxt: StOscStr};
          else if (c_i <= 7'h2f) dec_o = '{act: ActCollect, chg: 1'b1, nxt: StEscInt};
          else if (c_i == 7'h58 || c_i == 7'h7f) dec_o.act = ActNone;
          else if (c_i == 7'h5b) dec_o = '{act: ActNone, chg: 1'b1, nxt: StCsiEntry};
          else if (c_i == 7'h5d) dec_o = '{act: ActNone, chg: 1'b1, nxt: StOscParam};
          else dec_o = '{act: ActSend, chg: 1'b1, nxt: StGround};
        end
        StEscInt: begin
          if (c_i <= 7'h2f) dec_o.act = ActCollect;
          else if (c_i == 7'h7f) dec_o.act = ActNone;
          else dec_o = '{act: ActSend, chg: 1'b1, nxt: StGround};
        end
        StCsiEntry, StCsiParam: begin
          if (c_i <= 7'h2f) dec_o = '{act: ActCollect, chg: 1'b1, nxt: StCsiInt};
          else if (c_i <= 7'h39 || c_i == 7'h3b)
            dec_o = '{act: ActParam, chg: 1'b1, nxt: StCsiParam};
          else if (c_i == 7'h3a) dec_o = '{act: ActNone, chg: 1'b1, nxt: StCsiIgn};
          else if (c_i <= 7'h3f) begin
            if (st_i == StCsiEntry) dec_o = '{act: ActCollect, chg: 1'b1, nxt: StCsiParam};
            else dec_o = '{act: ActNone, chg: 1'b1, nxt: StCsiIgn};
          end else if (c_i == 7'h7f) dec_o.act = ActNone;
          else dec_o = '{act: ActSend, chg: 1'b1, nxt: StGround};
        end
        StCsiInt: begin
          if (c_i <= 7'h2f) dec_o.act = ActCollect;
          else if (c_i <= 7'h3f) dec_o = '{act: ActNone, chg: 1'b1, nxt: StCsiIgn};
          else if (c_i == 7'h7f) dec_o.act = ActNone;
          else dec_o = '{act: ActSend, chg: 1'b1, nxt: StGround};
        end
        StCsiIgn: begin
          if (c_i >= 7'h40 && c_i <= 7'h7e) dec_o = '{act: ActNone, chg: 1'b1, nxt: StGround};
        end
        StOscParam: begin
          if (c_i >= 7'h30 && c_i <= 7'h39) dec_o.act = ActParam;
          else if (c_i == 7'h3b) dec_o = '{act: ActParam, chg: 1'b1, nxt: StOscStr};
          else dec_o.act = ActOsc;
        end
        default: dec_o.act = ActOsc;
      endcase
    end
  end

endmodule

@@ hw/rtl/vtp_param_ram.sv @@
// Parameter store: synchronous RAM, one write and one read port, registered read.
// Depends on vtp_pkg.
module vtp_param_ram import vtp_pkg::*; #(
  parameter int unsigned Depth = MaxParamsDef,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [ValW-1:0] wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [ValW-1:0] rdata_o
);

  logic [ValW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/vt_escape_sequence_parser_top.sv @@
// VT escape sequence parser, top level. Uses vtp_pkg, vtp_decode, vtp_param_ram.
// A character is captured on acceptance, decoded with its RAM read in SRead, and its
// result written to the output register in SEmit. A new character is accepted only
// when the sequencer is idle and the output register is empty; a dispatch of N
// parameters gives N results, each read from the parameter RAM port. Output stalls hold it.
// Reset: asynchronous, clears control; the parameter RAM is cleared lazily by
// per-slot valid bits, so no clearing pass is needed.
module vt_escape_sequence_parser_top import vtp_pkg::*; #(
  parameter int unsigned MaxParams   = MaxParamsDef,
  parameter int unsigned OscBufBytes = OscBufBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [CodeW-1:0] code_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [1:0]       kind_o,
  output logic [1:0]       table_class_o,
  output logic [CodeW-1:0] char_out_o,
  output logic [6:0]       intermediate_o,
  output logic [4:0]       param_count_o,
  output logic [3:0]       param_index_o,
  output logic [ValW-1:0]  param_value_o,
  output logic             last_o
);

  localparam int unsigned AW = (MaxParams > 1) ? $clog2(MaxParams) : 1;
  localparam int unsigned CW = $clog2(MaxParams + 1);
  localparam int unsigned FW = $clog2(OscBufBytes);
  localparam logic [FW-1:0] FillMax = FW'(OscBufBytes - 1);
  localparam logic [CW-1:0] CntMax  = CW'(MaxParams);

  typedef enum logic [1:0] {SIdle, SRead, SEmit, SOut} fsm_e;

  fsm_e             fsm_q;
  pstate_e          st_q;
  logic [6:0]       inter_q;
  logic [CW-1:0]    cnt_q;
  logic [FW-1:0]    fill_q;
  logic [MaxParams-1:0] vld_q;
  logic [6:0]       c_q;
  logic             hi_q;
  logic [CodeW-1:0] code_q;
  decode_t          dec_q;
  pstate_e          dst_q;
  logic [CW-1:0]    idx_q;
  logic [CW-1:0]    runs_q;

  logic             ovalid_q;
  logic [1:0]       okind_q, ocls_q;
  logic [CodeW-1:0] ochar_q;
  logic [6:0]       ointer_q;
  logic [4:0]       ocnt_q;
  logic [3:0]       oidx_q;
  logic [ValW-1:0]  oval_q;
  logic             olast_q;

  decode_t          dec;
  pstate_e          st_eff;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [ValW-1:0]  wdata, rdata, pval;
  logic             out_free;

  assign st_eff = (st_q > StOscStr) ? StGround : st_q;

  vtp_decode u_dec (.st_i(st_eff), .c_i(code_q[6:0]), .dec_o(dec));

  // slot being written by a digit: count-1, or 0 when none yet
  logic [CW-1:0] slot;
  assign slot  = (cnt_q == '0) ? '0 : cnt_q - CW'(1);
  assign waddr = slot[AW-1:0];
  assign pval  = vld_q[idx_q[AW-1:0]] ? rdata : '0;
  assign wdata = ValW'(pval * ValW'(10)) + ValW'(c_q - 7'h30);

  // read address: target slot of a digit or slot 0 while decoding, else the run index
  always_comb begin
    raddr = idx_q[AW-1:0];
    if (fsm_q == SRead) raddr = (dec.act == ActParam) ? slot[AW-1:0] : '0;
  end

  assign we = (fsm_q == SEmit) && !hi_q && dec_q.act == ActParam && c_q != 7'h3b &&
              pval < ParamCap;

  vtp_param_ram #(.Depth(MaxParams)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign out_free = !ovalid_q || ready_i;
  assign ready_o  = (fsm_q == SIdle) && !ovalid_q;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= SIdle; st_q <= StGround; inter_q <= '0; cnt_q <= '0; fill_q <= '0;
      vld_q <= '0; ovalid_q <= 1'b0; idx_q <= '0; runs_q <= '0;
    end else begin
      if (ovalid_q && ready_i) ovalid_q <= 1'b0;
      case (fsm_q)
        SIdle: begin
          if (valid_i && ready_o) begin
            code_q <= code_i; c_q <= code_i[6:0]; hi_q <= code_i >= CodeW'(8'h80);
            fsm_q <= SRead;
          end
        end
        SRead: begin
          dec_q <= dec; dst_q <= st_eff;
          runs_q <= (cnt_q == '0) ? CW'(1) : cnt_q;
          // dispatch reads slot 0 first; a digit reads its target slot
          idx_q <= (dec.act == ActParam) ? slot : '0;
          fsm_q <= SEmit;
        end
        SEmit: begin
          if (hi_q) begin
            ovalid_q <= 1'b1; okind_q <= KindPrint; ocls_q <= ClsGround; ochar_q <= code_q;
            ointer_q <= '0; ocnt_q <= '0; oidx_q <= '0; oval_q <= '0; olast_q <= 1'b1;
            fsm_q <= SIdle;
          end else begin
            case (dec_q.act)
              ActSend: begin
                ovalid_q <= 1'b1; okind_q <= KindDispatch; ocls_q <= class_of(dst_q);
                ochar_q <= code_q; ointer_q <= inter_q; ocnt_q <= 5'(cnt_q);
                oidx_q <= 4'(idx_q); oval_q <= (cnt_q == '0) ? '0 : pval;
                olast_q <= (idx_q + CW'(1) == runs_q);
              end
              ActCollect: inter_q <= c_q;
              ActParam: begin
                if (c_q == 7'h3b) begin
                  if (cnt_q == '0) cnt_q <= (CntMax > CW'(1)) ? CW'(2) : CW'(1);
                  else if (cnt_q < CntMax) cnt_q <= cnt_q + CW'(1);
                end else begin
                  if (cnt_q == '0) cnt_q <= CW'(1);
                  if (we) vld_q[waddr] <= 1'b1;
                end
              end
              ActOsc: begin
                if (fill_q < FillMax) begin
                  fill_q <= fill_q + FW'(1);
                  ovalid_q <= 1'b1; okind_q <= KindOscByte; ocls_q <= ClsOsc;
                  ochar_q <= code_q; ointer_q <= '0; ocnt_q <= '0; oidx_q <= '0;
                  oval_q <= '0; olast_q <= 1'b1;
                end
              end
              ActOscEnd: begin
                ovalid_q <= 1'b1; okind_q <= KindOscEnd; ocls_q <= ClsOsc;
                ochar_q <= code_q; ointer_q <= inter_q; ocnt_q <= 5'(cnt_q);
                oidx_q <= '0; oval_q <= pval; olast_q <= 1'b1;
              end
              default: ;
            endcase
            // more dispatch results to come: keep the sequence state until the last
            if (dec_q.act == ActSend && idx_q + CW'(1) != runs_q) begin
              idx_q <= idx_q + CW'(1); fsm_q <= SOut;
            end else begin
              fsm_q <= SIdle;
              if (dec_q.chg) begin
                st_q <= dec_q.nxt;
                if (dec_q.nxt == StGround || dec_q.nxt == StEsc) begin
                  inter_q <= '0; cnt_q <= '0; fill_q <= '0; vld_q <= '0;
                end
              end else begin
                st_q <= dst_q;
              end
            end
          end
        end
        SOut: begin
          // RAM reads the data for idx_q here; wait for the output slot
          if (out_free) fsm_q <= SEmit;
        end
        default: fsm_q <= SIdle;
      endcase
    end
  end

  assign valid_o        = ovalid_q;
  assign kind_o         = okind_q;
  assign table_class_o  = ocls_q;
  assign char_out_o     = ochar_q;
  assign intermediate_o = ointer_q;
  assign param_count_o  = ocnt_q;
  assign param_index_o  = oidx_q;
  assign param_value_o  = oval_q;
  assign last_o         = olast_q;

endmodule

@@ test/vt_escape_sequence_parser_top_test.sv @@
// Self-checking testbench for the VT escape sequence parser top level.
// Depends on vtp_pkg and vt_escape_sequence_parser_top; holds its own parser predictor.
module vt_escape_sequence_parser_top_test;
  import vtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NParams = MaxParamsDef;
  localparam int unsigned OscLimit = OscBufBytesDef - 1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       tclass;
    logic [CodeW-1:0] ch;
    logic [6:0]       inter;
    logic [4:0]       cnt;
    logic [3:0]       idx;
    logic [ValW-1:0]  val;
    logic             last;
  } vt_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             valid_i = 1'b0;
  logic             ready_o;
  logic [CodeW-1:0] code_i = '0;
  logic             valid_o;
  logic             ready_i = 1'b0;
  logic [1:0]       kind_o;
  logic [1:0]       table_class_o;
  logic [CodeW-1:0] char_out_o;
  logic [6:0]       intermediate_o;
  logic [4:0]       param_count_o;
  logic [3:0]       param_index_o;
  logic [ValW-1:0]  param_value_o;
  logic             last_o;

  // Predictor state
  pstate_e         pred_state;
  logic [6:0]      pred_inter;
  logic [4:0]      pred_count;
  logic [ValW-1:0] pred_params [NParams];
  int unsigned     pred_osc_fill;

  vt_result_t  expected_q[$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  vt_escape_sequence_parser_top u_top (.*);

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void clear_sequence();
    pred_inter = '0;
    pred_count = '0;
    for (int i = 0; i < NParams; i++) pred_params[i] = '0;
    pred_osc_fill = 0;
  endfunction

  function automatic logic [1:0] state_class(pstate_e st);
    logic [1:0] cls;
    cls = ClsCsi;
    if (st == StGround) cls = ClsGround;
    else if (st == StEsc || st == StEscInt) cls = ClsEsc;
    else if (st == StOscParam || st == StOscStr) cls = ClsOsc;
    return cls;
  endfunction

  // Work out action and next state of a 7-bit character
  function automatic void decode_char(input pstate_e st, input int unsigned c,
                                      output act_e act, output logic chg,
                                      output pstate_e nxt);
    act = ActNone; chg = 1'b0; nxt = st;
    if (c < 'h20) begin
      if ((st == StOscParam || st == StOscStr) && c == 'h07) begin
        act = ActOscEnd; chg = 1; nxt = StGround;
      end else if (st == StOscStr && (c == 'h0a || c == 'h0d)) begin
        act = ActOscEnd; chg = 1; nxt = StGround;
      end else if (c == 0) begin
      end else if (c == 'h1b) begin
        chg = 1; nxt = StEsc;
      end else begin
        act = ActSend;
        if (c == 'h18 || c == 'h1a) begin
          chg = 1; nxt = StGround;
        end
      end
      return;
    end
    case (st)
      StGround: act = ActSend;
      StEsc: begin
        if (c == 'h21 || c == 'h50 || c == 'h5e || c == 'h5f || c == 'h6b) begin
          chg = 1; nxt = StOscStr;
        end else if (c <= 'h2f) begin
          act = ActCollect; chg = 1; nxt = StEscInt;
        end else if (c == 'h58 || c == 'h7f) begin
        end else if (c == 'h5b) begin
          chg = 1; nxt = StCsiEntry;
        end else if (c == 'h5d) begin
          chg = 1; nxt = StOscParam;
        end else begin
          act = ActSend; chg = 1; nxt = StGround;
        end
      end
      StEscInt: begin
        if (c <= 'h2f) act = ActCollect;
        else if (c != 'h7f) begin
          act = ActSend; chg = 1; nxt = StGround;
        end
      end
      StCsiEntry, StCsiParam: begin
        if (c <= 'h2f) begin
          act = ActCollect; chg = 1; nxt = StCsiInt;
        end else if (c <= 'h39 || c == 'h3b) begin
          act = ActParam; chg = 1; nxt = StCsiParam;
        end else if (c == 'h3a) begin
          chg = 1; nxt = StCsiIgn;
        end else if (c <= 'h3f) begin
          chg = 1;
          if (st == StCsiEntry) begin
            act = ActCollect; nxt = StCsiParam;
          end else nxt = StCsiIgn;
        end else if (c != 'h7f) begin
          act = ActSend; chg = 1; nxt = StGround;
        end
      end
      StCsiInt: begin
        if (c <= 'h2f) act = ActCollect;
        else if (c <= 'h3f) begin
          chg = 1; nxt = StCsiIgn;
        end else if (c != 'h7f) begin
          act = ActSend; chg = 1; nxt = StGround;
        end
      end
      StCsiIgn: begin
        if (c >= 'h40 && c <= 'h7e) begin
          chg = 1; nxt = StGround;
        end
      end
      StOscParam: begin
        if (c >= 'h30 && c <= 'h39) act = ActParam;
        else if (c == 'h3b) begin
          act = ActParam; chg = 1; nxt = StOscStr;
        end else act = ActOsc;
      end
      default: act = ActOsc;
    endcase
  endfunction

  // Predict the results of one character and advance the predictor
  task automatic predict_parse(input logic [CodeW-1:0] code);
    act_e        act;
    logic        chg;
    pstate_e     nxt;
    int unsigned runs;
    int unsigned slot;
    vt_result_t  r;
    if (code >= 'h80) begin
      r = '0;
      r.kind = KindPrint; r.ch = code; r.last = 1'b1;
      expected_q.push_back(r);
      return;
    end
    decode_char(pred_state, code, act, chg, nxt);
    case (act)
      ActSend: begin
        runs = (pred_count == 0) ? 1 : pred_count;
        for (int i = 0; i < runs; i++) begin
          r.kind = KindDispatch; r.tclass = state_class(pred_state); r.ch = code;
          r.inter = pred_inter; r.cnt = pred_count; r.idx = i[3:0];
          r.val = (pred_count == 0) ? '0 : pred_params[i];
          r.last = (i + 1 == runs);
          expected_q.push_back(r);
        end
      end
      ActCollect: pred_inter = code[6:0];
      ActParam: begin
        if (pred_count == 0) pred_count = 1;
        if (code == 'h3b) begin
          if (pred_count < NParams) pred_count++;
        end else begin
          slot = pred_count - 1;
          if (pred_params[slot] < ParamCap)
            pred_params[slot] = ValW'(pred_params[slot] * 10 + (code - 'h30));
        end
      end
      ActOsc: begin
        if (pred_osc_fill < OscLimit) begin
          pred_osc_fill++;
          r = '0;
          r.kind = KindOscByte; r.tclass = ClsOsc; r.ch = code; r.last = 1'b1;
          expected_q.push_back(r);
        end
      end
      ActOscEnd: begin
        r.kind = KindOscEnd; r.tclass = ClsOsc; r.ch = code; r.inter = pred_inter;
        r.cnt = pred_count; r.idx = '0; r.val = pred_params[0]; r.last = 1'b1;
        expected_q.push_back(r);
      end
      default: ;
    endcase
    if (chg) begin
      if (nxt == StGround || nxt == StEsc) clear_sequence();
      pred_state = nxt;
    end
  endtask

  // Send one character transaction, with random idling before it
  task automatic send_char(input int unsigned c);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    code_i  <= c[CodeW-1:0];
    predict_parse(c[CodeW-1:0]);
    do @(posedge clk_i); while (!ready_o);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Receiver: random stalls and result checking
  always @(posedge clk_i) begin
    vt_result_t got;
    vt_result_t exp_r;
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        got = {kind_o, table_class_o, char_out_o, intermediate_o, param_count_o,
               param_index_o, param_value_o, last_o};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp k%0d c%0d ch%h i%h n%0d x%0d v%0d l%0d, ",
                        "got k%0d c%0d ch%h i%h n%0d x%0d v%0d l%0d"},
                       exp_r.kind, exp_r.tclass, exp_r.ch, exp_r.inter, exp_r.cnt, exp_r.idx,
                       exp_r.val, exp_r.last, got.kind, got.tclass, got.ch, got.inter,
                       got.cnt, got.idx, got.val, got.last);
          end
        end
      end
      ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Directed: extremes, every state and the special cases
  task automatic test_directed();
    send_char(0); send_char('h41); send_char('h80); send_char('h10FFFF);
    send_char('h1FFFFF); send_char('h1b); send_string("[?12;34h");
    send_string("\033[99999;5m");           // value saturation
    send_string("\033[m");                  // dispatch with no parameters
    send_string("\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;42X"); // count saturation
    send_string("\033(B\033#8\033X\033[1:2m\033[1 $q");
    send_string("\033]0;title\007\033]52;x\n\033Pdata\r\033]7\007");
    send_char('h18); send_char('h1a); send_char('h7f);
    wait_drained();
  endtask

  // OSC overflow: just longer string than the buffer
  task automatic test_osc_overflow();
    send_string("\033]2;");
    for (int i = 0; i < 257; i++) send_char($urandom_range('h7e, 'h20));
    send_char('h07);
    wait_drained();
  endtask

  function automatic int unsigned random_char();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 5) return $urandom_range('h1FFFFF, 'h80);
    if (p < 15) return $urandom_range('h1f);
    if (p < 35) return $urandom_range('h39, 'h30);
    if (p < 45) return 'h3b;
    return $urandom_range('h7f, 'h20);
  endfunction

  // Random: mostly well formed sequences with random content
  task automatic test_random(input int unsigned items);
    int unsigned sent;
    int unsigned sel;
    sent = 0;
    while (sent < items) begin
      sel = $urandom_range(9);
      if (sel < 5) begin
        send_char('h1b); send_char('h5b); sent += 2;
        if ($urandom_range(3) == 0) begin send_char($urandom_range('h3f, 'h3c)); sent++; end
        repeat ($urandom_range(8)) begin send_char(random_char() % 'h80); sent++; end
        send_char($urandom_range('h7e, 'h40)); sent++;
      end else if (sel < 7) begin
        send_char('h1b); send_char('h5d); sent += 2;
        repeat ($urandom_range(6)) begin send_char($urandom_range('h7e, 'h20)); sent++; end
        send_char($urandom_range(2) == 0 ? 'h07 : ($urandom_range(1) ? 'h0a : 'h0d));
        sent++;
      end else begin
        repeat ($urandom_range(6, 1)) begin send_char(random_char()); sent++; end
      end
    end
    wait_drained();
  endtask

  initial begin
    mismatches = 0;
    pred_state = StGround;
    clear_sequence();
    send_idle_pct = 31; recv_idle_pct = 66;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_osc_overflow();
    test_random(20);
    send_idle_pct = 66; recv_idle_pct = 31;
    test_random(20);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(20);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run time limit
  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/vtp_pkg.sv
hw/rtl/vtp_decode.sv
hw/rtl/vtp_param_ram.sv
hw/rtl/vt_escape_sequence_parser_top.sv
test/vt_escape_sequence_parser_top_test.sv
